// ===== sv/sh4_mmu_tlb_translate_assert.svh =====
// Assertion macros for the translation block
`ifndef SH4_MMU_TLB_TRANSLATE_ASSERT_SVH
`define SH4_MMU_TLB_TRANSLATE_ASSERT_SVH

// antecedent in this cycle implies consequent in this cycle
`define SH4T_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define SH4T_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/sh4t_pkg.sv =====
// Types, codes and tables shared by the translation block
`timescale 1ns / 1ps
`default_nettype none
package sh4t_pkg;

   localparam int ITLB_ENTRIES = 4;

   localparam logic [2:0] ACT_READ   = 3'd0;
   localparam logic [2:0] ACT_WRITE  = 3'd1;
   localparam logic [2:0] ACT_IFETCH = 3'd2;
   localparam logic [2:0] ACT_SQW    = 3'd3;
   localparam logic [2:0] ACT_LOAD   = 3'd4;

   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_MISS = 3'd1;
   localparam logic [2:0] ST_MHIT = 3'd2;
   localparam logic [2:0] ST_PROT = 3'd3;
   localparam logic [2:0] ST_FW   = 3'd4;
   localparam logic [2:0] ST_BAD  = 3'd5;

   localparam logic [8:0] EV_RMISS = 9'h040;
   localparam logic [8:0] EV_WMISS = 9'h060;
   localparam logic [8:0] EV_FW    = 9'h080;
   localparam logic [8:0] EV_RPROT = 9'h0A0;
   localparam logic [8:0] EV_WPROT = 9'h0C0;
   localparam logic [8:0] EV_RBAD  = 9'h0E0;
   localparam logic [8:0] EV_WBAD  = 9'h100;
   localparam logic [8:0] EV_MHIT  = 9'h140;

   localparam logic [2:0] CSR_TE   = 3'd0;
   localparam logic [2:0] CSR_SVM  = 3'd1;
   localparam logic [2:0] CSR_SQMD = 3'd2;
   localparam logic [2:0] CSR_URB  = 3'd3;
   localparam logic [2:0] CSR_ASID = 3'd4;
   localparam logic [2:0] CSR_ORA  = 3'd5;

   localparam logic [5:0] SQ_AREA  = 6'h38;
   localparam logic [5:0] ORA_AREA = 6'h1F;

   localparam logic [5:0] LRU_SET  [ITLB_ENTRIES] = '{6'h00, 6'h20, 6'h14, 6'h0B};
   localparam logic [5:0] LRU_KEEP [ITLB_ENTRIES] = '{6'h07, 6'h39, 6'h3E, 6'h3F};

   typedef struct packed {
      logic [21:0] vpn;
      logic [7:0]  asid;
      logic [18:0] ppn;
      logic        valid;
      logic [1:0]  size;
      logic        shared;
      logic [1:0]  prot;
      logic        dirty;
   } entry_type;

   typedef struct packed {
      logic [31:0] va;
      logic        priv;
      logic        svm;
      logic [7:0]  asid;
   } lookup_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] virt_addr;
      logic        privileged;
      logic [5:0]  entry_index;
      logic [21:0] new_vpn;
      logic [7:0]  new_asid;
      logic [18:0] new_ppn;
      logic        new_valid;
      logic [1:0]  new_page_size;
      logic        new_shared;
      logic [1:0]  new_protection;
      logic        new_dirty;
   } req_type;

   typedef struct packed {
      logic [31:0] phys_addr;
      logic [2:0]  status;
      logic [8:0]  event_code;
      logic [5:0]  hit_entry;
   } rsp_type;

   function automatic logic [31:0] size_mask(input logic [1:0] size);
      logic [31:0] m;
      case (size)
         2'd0:    m = 32'hFFFF_FC00;
         2'd1:    m = 32'hFFFF_F000;
         2'd2:    m = 32'hFFFF_0000;
         default: m = 32'hFFF0_0000;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] map_addr(input entry_type e, input logic [31:0] va);
      logic [31:0] m;
      m = size_mask(e.size);
      return ({3'b000, e.ppn, 10'b0} & m) | (va & ~m);
   endfunction

   function automatic logic [1:0] lru_victim(input logic [5:0] lru);
      logic [1:0] v;
      logic       found;
      logic [5:0] key;
      v = 2'd0;
      found = 1'b0;
      for (int e = 0; e < ITLB_ENTRIES; e++) begin
         key = ~LRU_KEEP[e];
         if (!found && ((lru & (key | LRU_SET[e])) == key)) begin
            v = e[1:0];
            found = 1'b1;
         end
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== sv/sh4t_cell.sv =====
// One TLB entry cell: holds the entry and registers its match against the broadcast lookup
`timescale 1ns / 1ps
`default_nettype none
module sh4t_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire sh4t_pkg::entry_type wr_data,
   input  wire sh4t_pkg::lookup_type lookup,
   output sh4t_pkg::entry_type     entry,
   output logic                    hit
);
   import sh4t_pkg::*;

   entry_type   ent_ff;
   logic        valid_ff;
   logic        hit_ff;
   logic        hit_in;
   logic [31:0] m;
   logic        chk;

   always_comb begin
      m      = size_mask(ent_ff.size);
      chk    = !ent_ff.shared && (!lookup.priv || !lookup.svm);
      hit_in = valid_ff && (({ent_ff.vpn, 10'b0} & m) == (lookup.va & m))
               && (!chk || (ent_ff.asid == lookup.asid));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         if (wr_en) begin
            valid_ff <= wr_data.valid;
         end
      end
      if (wr_en) begin
         ent_ff <= wr_data;
      end
   end

   always_comb begin
      entry       = ent_ff;
      entry.valid = valid_ff;
   end
   assign hit = hit_ff;

endmodule
`default_nettype wire

// ===== sv/sh4_mmu_tlb_translate.sv =====
// Top level of the UTLB/ITLB address translation block
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/stall    | req_data (sh4t_pkg::req_type)
//  rsp     | out | rsp_valid/stall    | rsp_data (sh4t_pkg::rsp_type)
//  csr     | in  | csr_we             | csr_index, csr_wdata
// A transaction passes through capture, compare in every entry cell, select and resolve.
// The cell row compares all entries at once; the resolve step updates state and the result.
// Synchronous reset clears entry valid bits, the counter, LRU bits and config.
// A stalled result holds the resolve step; the next transaction is not captured until it completes.
`timescale 1ns / 1ps
`default_nettype none
`include "sh4_mmu_tlb_translate_assert.svh"
module sh4_mmu_tlb_translate #(
   parameter int UTLB_ENTRIES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire sh4t_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sh4t_pkg::rsp_type       rsp_data,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [7:0]         csr_wdata
);
   import sh4t_pkg::*;

   localparam int UW = $clog2(UTLB_ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CMP  = 4'b0010,
      S_SEL  = 4'b0100,
      S_RES  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   req_type     item_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff;
   logic        te_ff, svm_ff, sqmd_ff, ora_ff;
   logic [5:0]  urb_ff, rc_ff, rc_in, lru_ff, lru_in;
   logic [7:0]  asid_ff;

   lookup_type  lookup;
   entry_type   new_entry;
   entry_type   uent [UTLB_ENTRIES];
   entry_type   ient [ITLB_ENTRIES];
   logic [UTLB_ENTRIES-1:0] uhit, uwr;
   logic [ITLB_ENTRIES-1:0] ihit, iwr;

   logic        u_none_ff, u_multi_ff, i_none_ff, i_multi_ff;
   logic [UW-1:0] u_idx_ff;
   logic [1:0]  i_slot_ff;
   entry_type   u_sel_ff, i_sel_ff;
   logic        u_none_in, u_multi_in, i_none_in, i_multi_in;
   logic [UW-1:0] u_idx_in;
   logic [1:0]  i_slot_in;
   entry_type   u_sel_in, i_sel_in;

   logic        fire;
   logic        ub, byp, ora_hit, wr, do_lookup, refill;
   logic [1:0]  slot;
   entry_type   use_ent;
   logic [2:0]  st;
   logic [31:0] pa;
   logic [8:0]  ev;
   logic [5:0]  hit6, rc_inc;

   assign lookup = '{va: item_ff.virt_addr, priv: item_ff.privileged,
                     svm: svm_ff, asid: asid_ff};

   assign new_entry = '{vpn: item_ff.new_vpn, asid: item_ff.new_asid, ppn: item_ff.new_ppn,
                        valid: item_ff.new_valid, size: item_ff.new_page_size,
                        shared: item_ff.new_shared, prot: item_ff.new_protection,
                        dirty: item_ff.new_dirty};

   for (genvar g = 0; g < UTLB_ENTRIES; g++) begin : g_utlb
      sh4t_cell u_cell (
         .clock(clock), .reset(reset), .wr_en(uwr[g]), .wr_data(new_entry),
         .lookup(lookup), .entry(uent[g]), .hit(uhit[g])
      );
   end

   for (genvar g = 0; g < ITLB_ENTRIES; g++) begin : g_itlb
      sh4t_cell u_cell (
         .clock(clock), .reset(reset), .wr_en(iwr[g]), .wr_data(u_sel_ff),
         .lookup(lookup), .entry(ient[g]), .hit(ihit[g])
      );
   end

   always_comb begin
      u_none_in  = ~|uhit;
      u_multi_in = |(uhit & (uhit - 1'b1));
      i_none_in  = ~|ihit;
      i_multi_in = |(ihit & (ihit - 1'b1));
      u_idx_in   = '0;
      u_sel_in   = '0;
      i_slot_in  = '0;
      i_sel_in   = '0;
      for (int i = 0; i < UTLB_ENTRIES; i++) begin
         if (uhit[i]) begin
            u_idx_in = u_idx_in | i[UW-1:0];
            u_sel_in = u_sel_in | uent[i];
         end
      end
      for (int i = 0; i < ITLB_ENTRIES; i++) begin
         if (ihit[i]) begin
            i_slot_in = i_slot_in | i[1:0];
            i_sel_in  = i_sel_in | ient[i];
         end
      end
   end

   always_comb begin
      fire    = (state_ff == S_RES) && (!rsp_valid_ff || !rsp_stall);
      ub      = !item_ff.privileged && item_ff.virt_addr[31]
                && ((item_ff.virt_addr[31:26] != SQ_AREA) || sqmd_ff);
      byp     = (item_ff.virt_addr[31:29] == 3'd4) || (item_ff.virt_addr[31:29] == 3'd5)
                || (item_ff.virt_addr[31:29] == 3'd7);
      ora_hit = ora_ff && (item_ff.virt_addr[31:26] == ORA_AREA);
      wr      = (item_ff.action == ACT_WRITE) || (item_ff.action == ACT_SQW);
      hit6    = 6'(u_idx_ff);
      st      = ST_OK;
      pa      = '0;
      do_lookup = 1'b0;
      refill  = 1'b0;
      slot    = i_slot_ff;
      use_ent = i_sel_ff;
      rsp_in  = '0;
      lru_in  = lru_ff;
      case (item_ff.action)
         ACT_READ, ACT_WRITE, ACT_SQW: begin
            if (item_ff.action != ACT_SQW && ub) begin
               st = ST_BAD;
            end else if (item_ff.action != ACT_SQW && (!te_ff || byp || ora_hit)) begin
               pa = item_ff.virt_addr;
            end else begin
               do_lookup = 1'b1;
               if (u_none_ff) begin
                  st = ST_MISS;
               end else if (u_multi_ff) begin
                  st = ST_MHIT;
               end else begin
                  rsp_in.hit_entry = hit6;
                  pa = map_addr(u_sel_ff, item_ff.virt_addr);
                  if (!u_sel_ff.prot[1] && !item_ff.privileged) begin
                     st = ST_PROT;
                  end else if (wr && !u_sel_ff.prot[0]) begin
                     st = ST_PROT;
                  end else if (wr && !u_sel_ff.dirty) begin
                     st = ST_FW;
                  end
               end
            end
         end
         ACT_IFETCH: begin
            if (ub) begin
               st = ST_BAD;
            end else if (!te_ff || byp) begin
               pa = item_ff.virt_addr;
            end else begin
               if (i_none_ff) begin
                  do_lookup = 1'b1;
                  if (u_none_ff) begin
                     st = ST_MISS;
                  end else if (u_multi_ff) begin
                     st = ST_MHIT;
                  end else begin
                     rsp_in.hit_entry = hit6;
                     slot    = lru_victim(lru_ff);
                     refill  = 1'b1;
                     use_ent = u_sel_ff;
                  end
               end else if (i_multi_ff) begin
                  st = ST_MHIT;
               end
               if (st == ST_OK) begin
                  lru_in = (lru_ff & LRU_KEEP[slot]) | LRU_SET[slot];
                  pa     = map_addr(use_ent, item_ff.virt_addr);
                  if (!use_ent.prot[1] && !item_ff.privileged) begin
                     st = ST_PROT;
                  end
               end
            end
         end
         ACT_LOAD: begin
            rsp_in.hit_entry = item_ff.entry_index;
         end
         default: begin
         end
      endcase
      case (st)
         ST_MISS: ev = wr ? EV_WMISS : EV_RMISS;
         ST_MHIT: ev = EV_MHIT;
         ST_PROT: ev = wr ? EV_WPROT : EV_RPROT;
         ST_FW:   ev = EV_FW;
         ST_BAD:  ev = wr ? EV_WBAD : EV_RBAD;
         default: ev = '0;
      endcase
      rsp_in.phys_addr  = (st == ST_OK) ? pa : 32'h0;
      rsp_in.status     = st;
      rsp_in.event_code = ev;
      rc_inc = rc_ff + 6'd1;
      rc_in  = rc_ff;
      if (do_lookup) begin
         rc_in = (rc_inc == urb_ff) ? 6'd0 : rc_inc;
      end
      uwr = '0;
      iwr = '0;
      if (fire && item_ff.action == ACT_LOAD) begin
         uwr[item_ff.entry_index[UW-1:0]] = 1'b1;
      end
      if (fire && refill) begin
         iwr[slot] = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_CMP;
         S_CMP:   state_in = S_SEL;
         S_SEL:   state_in = S_RES;
         S_RES:   if (fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rc_ff        <= '0;
         lru_ff       <= '0;
         te_ff        <= 1'b0;
         svm_ff       <= 1'b0;
         sqmd_ff      <= 1'b0;
         ora_ff       <= 1'b0;
         urb_ff       <= '0;
         asid_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            rc_ff        <= rc_in;
            lru_ff       <= lru_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TE:   te_ff   <= csr_wdata[0];
               CSR_SVM:  svm_ff  <= csr_wdata[0];
               CSR_SQMD: sqmd_ff <= csr_wdata[0];
               CSR_URB:  urb_ff  <= csr_wdata[5:0];
               CSR_ASID: asid_ff <= csr_wdata;
               CSR_ORA:  ora_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      if (state_ff == S_IDLE && req_valid) begin
         item_ff <= req_data;
      end
      if (state_ff == S_SEL) begin
         u_none_ff  <= u_none_in;
         u_multi_ff <= u_multi_in;
         u_idx_ff   <= u_idx_in;
         u_sel_ff   <= u_sel_in;
         i_none_ff  <= i_none_in;
         i_multi_ff <= i_multi_in;
         i_slot_ff  <= i_slot_in;
         i_sel_ff   <= i_sel_in;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SH4T_ASSERT_NEXT(a_cmp_to_sel, clock, reset, state_ff == S_CMP, state_ff == S_SEL)
   `SH4T_ASSERT_NEXT(a_sel_to_res, clock, reset, state_ff == S_SEL, state_ff == S_RES)
   `SH4T_ASSERT_NOW(a_rc_update, clock, reset, !$past(reset) && !$stable(rc_ff), $past(fire))
   `SH4T_ASSERT_NOW(a_rsp_from_res, clock, reset, $rose(rsp_valid_ff), $past(fire))

endmodule
`default_nettype wire

// ===== sim/sh4_mmu_tlb_translate_tb.sv =====
// Self-checking testbench for the UTLB/ITLB address translation block
`timescale 1ns / 1ps
`default_nettype none

class xlate_scoreboard;
   bit          tlb_on;
   bit          svm;
   bit          sq_block;
   logic [5:0]  urb;
   logic [7:0]  asid;
   bit          ora_on;
   sh4t_pkg::entry_type utlb [64];
   sh4t_pkg::entry_type itlb [4];
   logic [5:0]  urc;
   logic [5:0]  lru;
   sh4t_pkg::rsp_type pending [$];
   int          errors;

   function void clear_state();
      tlb_on = 0; svm = 0; sq_block = 0; urb = '0; asid = '0; ora_on = 0;
      foreach (utlb[i]) utlb[i] = '0;
      foreach (itlb[i]) itlb[i] = '0;
      urc = '0; lru = '0; errors = 0;
   endfunction

   function void write_csr(logic [2:0] idx, logic [7:0] val);
      case (idx)
         sh4t_pkg::CSR_TE:   tlb_on = val[0];
         sh4t_pkg::CSR_SVM:  svm = val[0];
         sh4t_pkg::CSR_SQMD: sq_block = val[0];
         sh4t_pkg::CSR_URB:  urb = val[5:0];
         sh4t_pkg::CSR_ASID: asid = val;
         sh4t_pkg::CSR_ORA:  ora_on = val[0];
         default: ;
      endcase
   endfunction

   function logic [31:0] page_mask(logic [1:0] sz);
      case (sz)
         2'd0: return 32'hFFFF_FC00;
         2'd1: return 32'hFFFF_F000;
         2'd2: return 32'hFFFF_0000;
         default: return 32'hFFF0_0000;
      endcase
   endfunction

   function bit matches_entry(sh4t_pkg::entry_type e, logic [31:0] va, bit priv);
      logic [31:0] m;
      m = page_mask(e.size);
      if (!e.valid) return 0;
      if (({e.vpn, 10'b0} & m) != (va & m)) return 0;
      if (e.shared || (priv && svm)) return 1;
      return e.asid == asid;
   endfunction

   function logic [31:0] translate(sh4t_pkg::entry_type e, logic [31:0] va);
      logic [31:0] m;
      m = page_mask(e.size);
      return ({3'b000, e.ppn, 10'b0} & m) | (va & ~m);
   endfunction

   function logic [2:0] search_utlb(logic [31:0] va, bit priv, output logic [5:0] idx);
      int hits;
      hits = 0; idx = '0;
      urc = urc + 6'd1;
      if (urc == urb) urc = '0;
      for (int i = 0; i < 64; i++)
         if (matches_entry(utlb[i], va, priv)) begin
            idx = i[5:0]; hits++;
         end
      if (hits == 0) return sh4t_pkg::ST_MISS;
      if (hits > 1) return sh4t_pkg::ST_MHIT;
      return sh4t_pkg::ST_OK;
   endfunction

   function bit user_denied(logic [31:0] va, bit priv);
      if (priv || !va[31]) return 0;
      return (va[31:26] != sh4t_pkg::SQ_AREA) || sq_block;
   endfunction

   function logic [2:0] access_check(sh4t_pkg::entry_type e, bit priv, bit wr);
      if (!e.prot[1] && !priv) return sh4t_pkg::ST_PROT;
      if (wr && !e.prot[0]) return sh4t_pkg::ST_PROT;
      if (wr && !e.dirty) return sh4t_pkg::ST_FW;
      return sh4t_pkg::ST_OK;
   endfunction

   function logic [1:0] pick_victim();
      logic [5:0] keep [4];
      logic [5:0] setv [4];
      logic [5:0] key;
      keep = '{6'h07, 6'h39, 6'h3E, 6'h3F};
      setv = '{6'h00, 6'h20, 6'h14, 6'h0B};
      for (int e = 0; e < 4; e++) begin
         key = ~keep[e];
         if ((lru & (key | setv[e])) == key) return e[1:0];
      end
      return 2'd0;
   endfunction

   function void note_request(sh4t_pkg::req_type r);
      sh4t_pkg::rsp_type x;
      logic [2:0]  st;
      logic [5:0]  idx;
      logic [1:0]  slot;
      logic [5:0]  keep [4];
      logic [5:0]  setv [4];
      bit          wr;
      bit          bypass;
      int          hits;
      keep = '{6'h07, 6'h39, 6'h3E, 6'h3F};
      setv = '{6'h00, 6'h20, 6'h14, 6'h0B};
      x = '0; st = sh4t_pkg::ST_OK;
      wr = (r.action == sh4t_pkg::ACT_WRITE) || (r.action == sh4t_pkg::ACT_SQW);
      bypass = !tlb_on || r.virt_addr[31:29] == 3'd4 || r.virt_addr[31:29] == 3'd5
               || r.virt_addr[31:29] == 3'd7;
      case (r.action)
         sh4t_pkg::ACT_READ, sh4t_pkg::ACT_WRITE: begin
            if (user_denied(r.virt_addr, r.privileged)) st = sh4t_pkg::ST_BAD;
            else if (bypass || (ora_on && r.virt_addr[31:26] == sh4t_pkg::ORA_AREA))
               x.phys_addr = r.virt_addr;
            else begin
               st = search_utlb(r.virt_addr, r.privileged, idx);
               if (st == sh4t_pkg::ST_OK) begin
                  x.hit_entry = idx;
                  x.phys_addr = translate(utlb[idx], r.virt_addr);
                  st = access_check(utlb[idx], r.privileged,
                                    r.action == sh4t_pkg::ACT_WRITE);
               end
            end
         end
         sh4t_pkg::ACT_IFETCH: begin
            if (user_denied(r.virt_addr, r.privileged)) st = sh4t_pkg::ST_BAD;
            else if (bypass) x.phys_addr = r.virt_addr;
            else begin
               hits = 0; slot = '0;
               for (int i = 0; i < 4; i++)
                  if (matches_entry(itlb[i], r.virt_addr, r.privileged)) begin
                     slot = i[1:0]; hits++;
                  end
               if (hits == 0) begin
                  st = search_utlb(r.virt_addr, r.privileged, idx);
                  if (st == sh4t_pkg::ST_OK) begin
                     x.hit_entry = idx;
                     slot = pick_victim();
                     itlb[slot] = utlb[idx];
                  end
               end else if (hits > 1) st = sh4t_pkg::ST_MHIT;
               if (st == sh4t_pkg::ST_OK) begin
                  lru = (lru & keep[slot]) | setv[slot];
                  x.phys_addr = translate(itlb[slot], r.virt_addr);
                  if (!itlb[slot].prot[1] && !r.privileged) st = sh4t_pkg::ST_PROT;
               end
            end
         end
         sh4t_pkg::ACT_SQW: begin
            st = search_utlb(r.virt_addr, r.privileged, idx);
            if (st == sh4t_pkg::ST_OK) begin
               x.hit_entry = idx;
               x.phys_addr = translate(utlb[idx], r.virt_addr);
               st = access_check(utlb[idx], r.privileged, 1);
            end
         end
         sh4t_pkg::ACT_LOAD: begin
            utlb[r.entry_index] = '{r.new_vpn, r.new_asid, r.new_ppn, r.new_valid,
                                   r.new_page_size, r.new_shared, r.new_protection,
                                   r.new_dirty};
            x.hit_entry = r.entry_index;
         end
         default: ;
      endcase
      if (st != sh4t_pkg::ST_OK) x.phys_addr = '0;
      x.status = st;
      case (st)
         sh4t_pkg::ST_MISS: x.event_code = wr ? sh4t_pkg::EV_WMISS : sh4t_pkg::EV_RMISS;
         sh4t_pkg::ST_MHIT: x.event_code = sh4t_pkg::EV_MHIT;
         sh4t_pkg::ST_PROT: x.event_code = wr ? sh4t_pkg::EV_WPROT : sh4t_pkg::EV_RPROT;
         sh4t_pkg::ST_FW:   x.event_code = sh4t_pkg::EV_FW;
         sh4t_pkg::ST_BAD:  x.event_code = wr ? sh4t_pkg::EV_WBAD : sh4t_pkg::EV_RBAD;
         default: x.event_code = '0;
      endcase
      pending.push_back(x);
   endfunction

   function void check_result(sh4t_pkg::rsp_type got);
      sh4t_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.phys_addr !== want.phys_addr) begin
         $display("%0t: phys_addr exp %h got %h", $time, want.phys_addr, got.phys_addr);
         errors++;
      end
      if (got.status !== want.status) begin
         $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
         errors++;
      end
      if (got.event_code !== want.event_code) begin
         $display("%0t: event_code exp %h got %h", $time, want.event_code, got.event_code);
         errors++;
      end
      if (got.hit_entry !== want.hit_entry) begin
         $display("%0t: hit_entry exp %0d got %0d", $time, want.hit_entry, got.hit_entry);
         errors++;
      end
   endfunction
endclass

module sh4_mmu_tlb_translate_tb;
   import sh4t_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1;
   rsp_type rsp_data;
   logic    csr_we = 0;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   xlate_scoreboard sb;
   int      idle_cycles = 0;
   logic [31:0] known_va [$];

   sh4_mmu_tlb_translate i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= 5000) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // random stall on the result side
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
         rsp_stall = (n != 0);
         repeat (n) @(negedge clock);
         rsp_stall = 0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [7:0] val);
      csr_we = 1; csr_index = idx; csr_wdata = val;
      @(posedge clock);
      sb.write_csr(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic send(req_type r, bit burst);
      int n;
      n = burst ? 0 : $urandom_range(0, 12);
      repeat (n) @(negedge clock);
      req_data = r; req_valid = 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic req_type load_item(logic [5:0] idx, logic [31:0] va, bit wide);
      req_type r;
      r = '0;
      r.action = ACT_LOAD;
      r.virt_addr = $urandom;
      r.entry_index = idx;
      r.new_vpn = va[31:10];
      r.new_asid = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
      r.new_ppn = 19'($urandom);
      r.new_valid = $urandom_range(0, 7) != 0;
      r.new_page_size = wide ? 2'($urandom) : 2'($urandom_range(0, 1));
      r.new_shared = 1'($urandom);
      r.new_protection = 2'($urandom);
      r.new_dirty = 1'($urandom);
      return r;
   endfunction

   function automatic req_type access_item();
      req_type r;
      logic [31:0] va;
      r = '0;
      r.action = 3'($urandom_range(0, 3));
      if ($urandom_range(0, 15) == 0) r.action = 3'($urandom_range(5, 7));
      if (known_va.size() != 0 && $urandom_range(0, 3) != 0)
         va = known_va[$urandom_range(0, known_va.size() - 1)] ^ 32'($urandom_range(0, 4095));
      else va = $urandom;
      r.virt_addr = va;
      r.privileged = 1'($urandom);
      r.entry_index = 6'($urandom); r.new_vpn = 22'($urandom); r.new_asid = 8'($urandom);
      r.new_ppn = 19'($urandom); r.new_valid = 1'($urandom);
      r.new_page_size = 2'($urandom);
      r.new_shared = 1'($urandom); r.new_protection = 2'($urandom);
      r.new_dirty = 1'($urandom);
      return r;
   endfunction

   task automatic config_phase(bit te, bit svm, bit sqmd, logic [5:0] urb,
                               logic [7:0] asid, bit ora);
      csr_write(CSR_TE, {7'b0, te});
      csr_write(CSR_SVM, {7'b0, svm});
      csr_write(CSR_SQMD, {7'b0, sqmd});
      csr_write(CSR_URB, {2'b0, urb});
      csr_write(CSR_ASID, asid);
      csr_write(CSR_ORA, {7'b0, ora});
   endtask

   initial begin
      req_type r;
      logic [31:0] va;
      logic [31:0] dir_va [8];
      sb = new();
      sb.clear_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: entries, then accesses of each kind in several address regions
      config_phase(1, 0, 0, 6'd0, 8'd0, 1);
      dir_va = '{32'h0000_0000, 32'h7FFF_FC00, 32'h0012_3400, 32'h1000_0000,
                 32'hC000_0000, 32'hE000_0000, 32'h3FF0_0000, 32'h0012_3400};
      for (int i = 0; i < 8; i++) begin
         r = '0;
         r.action = ACT_LOAD; r.entry_index = (i == 7) ? 6'd63 : 6'(i);
         r.new_vpn = dir_va[i][31:10]; r.new_ppn = {19{i[0]}};
         r.new_valid = 1; r.new_page_size = 2'(i); r.new_shared = (i > 3);
         r.new_protection = 2'(i); r.new_dirty = i[1]; r.new_asid = (i == 2) ? 8'hFF : 8'h00;
         send(r, 0);
         known_va.push_back(dir_va[i]);
      end
      for (int i = 0; i < 12; i++) begin
         r = '0;
         r.action = 3'(i % 5);
         r.privileged = i[0];
         case (i)
            0: r.virt_addr = 32'h0000_0000;
            1: r.virt_addr = 32'h7FFF_FFFF;
            2: r.virt_addr = 32'h8000_0000;
            3: r.virt_addr = 32'hE000_0010;
            4: r.virt_addr = 32'hFFFF_FFFF;
            5: r.virt_addr = 32'h7C00_0000;
            6: r.virt_addr = 32'h0012_3456;
            7: r.virt_addr = 32'hA000_0000;
            8: r.virt_addr = 32'h1000_0004;
            9: r.virt_addr = 32'h3FF1_2345;
            default: r.virt_addr = 32'hE3FF_FFFF;
         endcase
         send(r, 0);
      end
      r = '0; r.action = 3'd7; r.virt_addr = 32'hFFFF_FFFF; send(r, 0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: config_phase(1, 1, 1, 6'd63, 8'hFF, 0);
            1: config_phase(1, 0, 0, 6'd1, 8'd1, 1);
            2: config_phase(0, 1, 0, 6'd5, 8'd0, 0);
            default: config_phase(1, 1'($urandom), 1'($urandom), 6'($urandom),
                                  8'($urandom_range(0, 2)), 1'($urandom));
         endcase
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               va = $urandom;
               if ($urandom_range(0, 1)) va[31] = 0;
               r = load_item(6'($urandom), va, $urandom_range(0, 7) == 0);
               known_va.push_back(va);
            end else r = access_item();
            send(r, $urandom_range(0, 4) == 0);
         end
         drain();
      end
      if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
